// ===== sv/ramr_pkg.sv =====
package ramr_pkg;

    localparam int NUM_IN_W  = 32;
    localparam int DEN_IN_W  = 31;
    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 63;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_MUL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMB,
        ST_MAG,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== sv/ramr_div.sv =====
module ramr_div #(
    parameter int W = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_dvd_a,
    input  logic [W-1:0]          i_dvd_b,
    input  logic [W-1:0]          i_dvs,
    output ramr_pkg::t_div_stat   o_stat,
    output logic [W-1:0]          o_quo_a,
    output logic [W-1:0]          o_quo_b
);

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_dvs;
    logic [W-1:0]     r_rem_a;
    logic [W-1:0]     r_rem_b;
    logic [W-1:0]     r_q_a;
    logic [W-1:0]     r_q_b;

    logic [W:0] sh_a;
    logic [W:0] sh_b;
    logic [W:0] df_a;
    logic [W:0] df_b;

    // restoring step, one quotient bit per cycle for both dividends
    assign sh_a = {r_rem_a, r_q_a[W-1]};
    assign sh_b = {r_rem_b, r_q_b[W-1]};
    assign df_a = sh_a - {1'b0, r_dvs};
    assign df_b = sh_b - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs   <= i_dvs;
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_q_a   <= i_dvd_a;
            r_q_b   <= i_dvd_b;
        end else if (r_busy) begin
            r_rem_a <= df_a[W] ? sh_a[W-1:0] : df_a[W-1:0];
            r_rem_b <= df_b[W] ? sh_b[W-1:0] : df_b[W-1:0];
            r_q_a   <= {r_q_a[W-2:0], ~df_a[W]};
            r_q_b   <= {r_q_b[W-2:0], ~df_b[W]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo_a     = r_q_a;
    assign o_quo_b     = r_q_b;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finishing step");

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_dvs != '0) |-> (r_rem_a < r_dvs) && (r_rem_b < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

// ===== sv/rational_add_mul_reduce_top.sv =====
// Flow: a zero denominator goes straight to the output stage with the error flag; a zero
// numerator passes the serial multiply, combine and magnitude steps and gives 0/1; else
// binary gcd (one step a cycle) and restoring divide follow before the result is output.
// Throughput: one item at a time; the next is taken once the result is in the output
// register. The number of gcd steps is set by the operand values.
// Reset: synchronous active low, clears the state machine and output valid.
module rational_add_mul_reduce_top #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic                                     i_command,
    input  logic signed [ramr_pkg::NUM_IN_W-1:0]     i_num_a,
    input  logic        [ramr_pkg::DEN_IN_W-1:0]     i_den_a,
    input  logic signed [ramr_pkg::NUM_IN_W-1:0]     i_num_b,
    input  logic        [ramr_pkg::DEN_IN_W-1:0]     i_den_b,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [ramr_pkg::RES_NUM_W-1:0]    o_result_num,
    output logic        [ramr_pkg::RES_DEN_W-1:0]    o_result_den,
    output logic                                     o_div_zero_error
);

    localparam int OB    = OPERAND_BITS;
    localparam int M     = 2 * OB;
    localparam int CNT_W = $clog2(OB);
    localparam int RN_W  = ramr_pkg::RES_NUM_W;
    localparam int RD_W  = ramr_pkg::RES_DEN_W;

    ramr_pkg::t_state    r_state;
    ramr_pkg::t_state    n_state;
    ramr_pkg::t_div_stat div_stat;

    logic             div_start;
    logic             out_load;

    logic             r_mul;
    logic             r_sgn_a;
    logic             r_sgn_b;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [OB-1:0]    r_mc1;
    logic [OB-1:0]    r_mc2;
    logic [OB-1:0]    r_mc3;
    logic [OB-1:0]    r_mp1;
    logic [OB-1:0]    r_mp2;
    logic [OB-1:0]    r_mp3;
    logic [M-1:0]     r_acc1;
    logic [M-1:0]     r_acc2;
    logic [M-1:0]     r_acc3;
    logic [M-1:0]     r_n;
    logic [M-1:0]     r_u;
    logic [M-1:0]     r_v;
    logic [M-1:0]     r_mag;
    logic [M-1:0]     r_den;

    logic signed [RN_W-1:0] r_res_num;
    logic        [RD_W-1:0] r_res_den;
    logic                   r_res_err;

    logic                   r_out_valid;
    logic signed [RN_W-1:0] r_out_num;
    logic        [RD_W-1:0] r_out_den;
    logic                   r_out_err;

    logic [OB-1:0] in_na;
    logic [OB-1:0] in_nb;
    logic [OB-1:0] in_mag_a;
    logic [OB-1:0] in_mag_b;
    logic [OB-2:0] in_da;
    logic [OB-2:0] in_db;
    logic          den_zero;

    logic [OB:0]   ps1;
    logic [OB:0]   ps2;
    logic [OB:0]   ps3;

    logic          t1_neg;
    logic [M-1:0]  t1;
    logic [M-1:0]  t2;
    logic [M-1:0]  sum_n;
    logic [M-1:0]  mag_n;
    logic          mag_zero;

    logic [M:0]    d_uv;
    logic [M:0]    d_vu;
    logic          u_eq_v;

    logic [M-1:0]  q_a;
    logic [M-1:0]  q_b;
    logic [M-1:0]  q_signed;

    // operand fields: low OB bits of numerators as sign and magnitude, low OB-1 bits of denominators
    assign in_na    = i_num_a[OB-1:0];
    assign in_nb    = i_num_b[OB-1:0];
    assign in_mag_a = in_na[OB-1] ? (~in_na + OB'(1)) : in_na;
    assign in_mag_b = in_nb[OB-1] ? (~in_nb + OB'(1)) : in_nb;
    assign in_da    = i_den_a[OB-2:0];
    assign in_db    = i_den_b[OB-2:0];
    assign den_zero = (in_da == '0) || (in_db == '0);

    // shift-add multipliers, one multiplier bit a cycle
    assign ps1 = {1'b0, r_acc1[M-1:OB]} + {1'b0, (r_mp1[0] ? r_mc1 : {OB{1'b0}})};
    assign ps2 = {1'b0, r_acc2[M-1:OB]} + {1'b0, (r_mp2[0] ? r_mc2 : {OB{1'b0}})};
    assign ps3 = {1'b0, r_acc3[M-1:OB]} + {1'b0, (r_mp3[0] ? r_mc3 : {OB{1'b0}})};

    assign t1_neg = r_mul ? (r_sgn_a ^ r_sgn_b) : r_sgn_a;
    assign t1     = t1_neg ? (~r_acc1 + M'(1)) : r_acc1;
    assign t2     = r_mul ? '0 : (r_sgn_b ? (~r_acc2 + M'(1)) : r_acc2);
    assign sum_n  = t1 + t2;

    assign mag_n    = r_n[M-1] ? (~r_n + M'(1)) : r_n;
    assign mag_zero = (r_n == '0);

    assign d_uv   = {1'b0, r_u} - {1'b0, r_v};
    assign d_vu   = {1'b0, r_v} - {1'b0, r_u};
    assign u_eq_v = (r_u == r_v);

    assign q_signed = r_neg ? (~q_a + M'(1)) : q_a;

    ramr_div #(
        .W (M)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd_a (r_mag),
        .i_dvd_b (r_den),
        .i_dvs   (r_u),
        .o_stat  (div_stat),
        .o_quo_a (q_a),
        .o_quo_b (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ramr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ramr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = den_zero ? ramr_pkg::ST_DONE : ramr_pkg::ST_MUL;
                end
            end
            ramr_pkg::ST_MUL: begin
                if (r_cnt == CNT_W'(OB - 1)) begin
                    n_state = ramr_pkg::ST_COMB;
                end
            end
            ramr_pkg::ST_COMB: begin
                n_state = ramr_pkg::ST_MAG;
            end
            ramr_pkg::ST_MAG: begin
                n_state = mag_zero ? ramr_pkg::ST_DONE : ramr_pkg::ST_GCD;
            end
            ramr_pkg::ST_GCD: begin
                if (u_eq_v) begin
                    div_start = 1'b1;
                    n_state   = ramr_pkg::ST_DIV;
                end
            end
            ramr_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ramr_pkg::ST_DONE;
                end
            end
            ramr_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ramr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ramr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == ramr_pkg::ST_MUL) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ramr_pkg::ST_IDLE: begin
                r_mul     <= (i_command == ramr_pkg::CMD_MUL);
                r_sgn_a   <= in_na[OB-1];
                r_sgn_b   <= in_nb[OB-1];
                r_mc1     <= in_mag_a;
                r_mc2     <= in_mag_b;
                r_mc3     <= {1'b0, in_da};
                r_mp1     <= (i_command == ramr_pkg::CMD_MUL) ? in_mag_b : {1'b0, in_db};
                r_mp2     <= {1'b0, in_da};
                r_mp3     <= {1'b0, in_db};
                r_acc1    <= '0;
                r_acc2    <= '0;
                r_acc3    <= '0;
                r_res_num <= '0;
                r_res_den <= '0;
                r_res_err <= 1'b1;
            end
            ramr_pkg::ST_MUL: begin
                r_acc1 <= {ps1, r_acc1[OB-1:1]};
                r_acc2 <= {ps2, r_acc2[OB-1:1]};
                r_acc3 <= {ps3, r_acc3[OB-1:1]};
                r_mp1  <= r_mp1 >> 1;
                r_mp2  <= r_mp2 >> 1;
                r_mp3  <= r_mp3 >> 1;
            end
            ramr_pkg::ST_COMB: begin
                r_n <= sum_n;
            end
            ramr_pkg::ST_MAG: begin
                r_neg     <= r_n[M-1];
                r_u       <= mag_n;
                r_mag     <= mag_n;
                r_v       <= r_acc3;
                r_den     <= r_acc3;
                r_res_num <= '0;
                r_res_den <= RD_W'(1);
                r_res_err <= 1'b0;
            end
            ramr_pkg::ST_GCD: begin
                // binary gcd; common factors of two come off the dividends directly
                if (u_eq_v) begin
                    r_u <= r_u;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u   <= r_u >> 1;
                    r_v   <= r_v >> 1;
                    r_mag <= r_mag >> 1;
                    r_den <= r_den >> 1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (!d_uv[M]) begin
                    r_u <= d_uv[M:1];
                end else begin
                    r_v <= d_vu[M:1];
                end
            end
            ramr_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    r_res_num <= RN_W'(signed'(q_signed));
                    r_res_den <= RD_W'(q_b);
                    r_res_err <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_num <= r_res_num;
            r_out_den <= r_res_den;
            r_out_err <= r_res_err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_num     = r_out_num;
    assign o_result_den     = r_out_den;
    assign o_div_zero_error = r_out_err;

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ramr_pkg::ST_GCD) |-> (r_u != '0) && (r_v != '0))
        else $error("gcd operand reached zero");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ramr_pkg::ST_DIV))
        else $error("divider finished outside divide state");

    a_err_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_num == '0) && (r_out_den == '0))
        else $error("error beat carries a non-zero result");

    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_err) |-> (r_out_den != '0))
        else $error("result beat with zero denominator");

endmodule

// ===== tb/ramr_result_checker.sv =====
module ramr_result_checker #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_command,
    input  logic signed [ramr_pkg::NUM_IN_W-1:0]  i_num_a,
    input  logic        [ramr_pkg::DEN_IN_W-1:0]  i_den_a,
    input  logic signed [ramr_pkg::NUM_IN_W-1:0]  i_num_b,
    input  logic        [ramr_pkg::DEN_IN_W-1:0]  i_den_b,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [ramr_pkg::RES_NUM_W-1:0] i_result_num,
    input  logic        [ramr_pkg::RES_DEN_W-1:0] i_result_den,
    input  logic                                  i_div_zero_error,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ramr_pkg::RES_NUM_W-1:0] num;
        logic        [ramr_pkg::RES_DEN_W-1:0] den;
        logic                                  dz;
    } t_reduced;

    t_reduced reduced_q[$];
    t_reduced want;
    int       fails = 0;

    function automatic t_reduced reduced_fraction(
        input logic        cmd,
        input logic [31:0] num_a,
        input logic [30:0] den_a,
        input logic [31:0] num_b,
        input logic [30:0] den_b
    );
        logic signed [63:0] na, nb, n;
        logic [63:0]        da, db, d, mag, x, y, r, den_mask;
        t_reduced           res;
        den_mask = (64'd1 << (OPERAND_BITS - 1)) - 64'd1;
        na = $signed(64'(num_a) << (64 - OPERAND_BITS)) >>> (64 - OPERAND_BITS);
        nb = $signed(64'(num_b) << (64 - OPERAND_BITS)) >>> (64 - OPERAND_BITS);
        da = 64'(den_a) & den_mask;
        db = 64'(den_b) & den_mask;
        res.num = '0;
        res.den = '0;
        res.dz  = 1'b0;
        if (da == 64'd0 || db == 64'd0) begin
            res.dz = 1'b1;
            return res;
        end
        if (cmd == ramr_pkg::CMD_MUL)
            n = na * nb;
        else
            n = na * $signed(db) + nb * $signed(da);
        d = da * db;
        if (n == 64'sd0) begin
            res.den = 63'd1;
            return res;
        end
        mag = n[63] ? -n : n;
        x = mag;
        y = d;
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        mag = mag / x;
        d = d / x;
        res.num = n[63] ? -mag : mag;
        res.den = d[62:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (reduced_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%t: result beat with none pending: %0d/%0d err %0b",
                                 $realtime, i_result_num, i_result_den, i_div_zero_error);
                end else begin
                    want = reduced_q.pop_front();
                    if (i_result_num !== want.num || i_result_den !== want.den ||
                        i_div_zero_error !== want.dz) begin
                        fails++;
                        if (fails <= 10)
                            $display("%t: mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                                     $realtime, want.num, want.den, want.dz,
                                     i_result_num, i_result_den, i_div_zero_error);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                reduced_q.push_back(reduced_fraction(i_command, i_num_a, i_den_a,
                                                     i_num_b, i_den_b));
        end
        o_fail_count <= fails;
        o_pending    <= reduced_q.size();
    end

endmodule

// ===== tb/rational_add_mul_reduce_top_tb.sv =====
module rational_add_mul_reduce_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 RANDOM_ITEMS = 1600;
    localparam logic signed [31:0] NUM_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] NUM_MAX      = 32'sh7fff_ffff;
    localparam logic        [30:0] DEN_MAX      = 31'h7fff_ffff;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    logic                                  i_command = ramr_pkg::CMD_ADD;
    logic signed [ramr_pkg::NUM_IN_W-1:0]  i_num_a = '0;
    logic        [ramr_pkg::DEN_IN_W-1:0]  i_den_a = '0;
    logic signed [ramr_pkg::NUM_IN_W-1:0]  i_num_b = '0;
    logic        [ramr_pkg::DEN_IN_W-1:0]  i_den_b = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b0;
    logic signed [ramr_pkg::RES_NUM_W-1:0] o_result_num;
    logic        [ramr_pkg::RES_DEN_W-1:0] o_result_den;
    logic                                  o_div_zero_error;

    int fail_count;
    int pending;
    int ready_mode = 0;
    int ready_seg  = 0;

    rational_add_mul_reduce_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_num_a          (i_num_a),
        .i_den_a          (i_den_a),
        .i_num_b          (i_num_b),
        .i_den_b          (i_den_b),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_num     (o_result_num),
        .o_result_den     (o_result_den),
        .o_div_zero_error (o_div_zero_error)
    );

    ramr_result_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_num_a          (i_num_a),
        .i_den_a          (i_den_a),
        .i_num_b          (i_num_b),
        .i_den_b          (i_den_b),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_result_num     (o_result_num),
        .i_result_den     (o_result_den),
        .i_div_zero_error (o_div_zero_error),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: segments of free flow, light, heavy and very sparse ready
    always @(posedge i_clk) begin
        if (ready_seg == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_seg  <= $urandom_range(20, 400);
        end else begin
            ready_seg <= ready_seg - 1;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send_fractions(
        input logic               cmd,
        input logic signed [31:0] na,
        input logic        [30:0] da,
        input logic signed [31:0] nb,
        input logic        [30:0] db
    );
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_num_a    <= na;
        i_den_a    <= da;
        i_num_b    <= nb;
        i_den_b    <= db;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic signed [31:0] random_numerator();
        int v;
        case ($urandom_range(0, 7))
            0: begin
                v = $urandom_range(0, 40);
                return v - 20;
            end
            1: begin
                case ($urandom_range(0, 4))
                    0: return NUM_MIN;
                    1: return NUM_MAX;
                    2: return -32'sd1;
                    3: return 32'sd0;
                    default: return 32'sd1;
                endcase
            end
            2: begin
                v = 1 << $urandom_range(0, 30);
                return $urandom_range(0, 1) ? -v : v;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] random_denominator();
        int sel;
        sel = $urandom_range(0, 31);
        if (sel == 0)
            return 31'd0;
        else if (sel <= 2)
            return DEN_MAX;
        else if (sel <= 8)
            return 31'($urandom_range(1, 20));
        else if (sel <= 11)
            return 31'(1 << $urandom_range(0, 30));
        else
            return 31'($urandom);
    endfunction

    initial begin
        logic               cmd;
        logic signed [31:0] na, nb;
        logic        [30:0] da, db;
        int                 burst_left;
        int                 gap;
        int                 f;
        int                 lim;

        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_fractions(ramr_pkg::CMD_ADD, 1, 2, 1, 3);
        send_fractions(ramr_pkg::CMD_MUL, 2, 3, 3, 4);
        send_fractions(ramr_pkg::CMD_ADD, 1, 0, 1, 1);
        send_fractions(ramr_pkg::CMD_MUL, 1, 5, 1, 0);
        send_fractions(ramr_pkg::CMD_ADD, 0, 0, 0, 0);
        send_fractions(ramr_pkg::CMD_MUL, 0, 7, 5, 9);
        send_fractions(ramr_pkg::CMD_ADD, 1, 2, -1, 2);
        send_fractions(ramr_pkg::CMD_ADD, 0, 1, 0, 1);
        send_fractions(ramr_pkg::CMD_MUL, NUM_MIN, 1, NUM_MIN, 1);
        send_fractions(ramr_pkg::CMD_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
        send_fractions(ramr_pkg::CMD_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
        send_fractions(ramr_pkg::CMD_MUL, NUM_MAX, 1, NUM_MIN, 1);
        send_fractions(ramr_pkg::CMD_MUL, NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX);
        send_fractions(ramr_pkg::CMD_ADD, NUM_MAX, 1, NUM_MAX, 1);
        send_fractions(ramr_pkg::CMD_ADD, NUM_MIN, 1, NUM_MIN, 1);
        send_fractions(ramr_pkg::CMD_ADD, -3, 4, 1, 4);
        send_fractions(ramr_pkg::CMD_MUL, -6, DEN_MAX, 7, 1);
        send_fractions(ramr_pkg::CMD_MUL, -5, 3, -6, 5);
        send_fractions(ramr_pkg::CMD_ADD, -1, DEN_MAX, 0, 1);
        send_fractions(ramr_pkg::CMD_ADD, NUM_MAX, DEN_MAX, 0, DEN_MAX);
        send_fractions(ramr_pkg::CMD_MUL, 3, 31'h4000_0000, 5, 31'h4000_0000);
        send_fractions(ramr_pkg::CMD_ADD, 32'sh5555_5555, 31'h2aaa_aaaa,
                       32'shaaaa_aaaa, 31'h5555_5555);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
                burst_left = 0;
            end
            if (burst_left == 0) begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, $urandom_range(1, 400));
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            cmd = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 2) begin
                // shared factor in every field, so the gcd is large
                f   = $urandom_range(2, 65535);
                lim = 32'h7fff_ffff / f;
                na  = $urandom_range(0, lim) * f;
                nb  = $urandom_range(0, lim) * f;
                da  = 31'($urandom_range(1, lim) * f);
                db  = 31'($urandom_range(1, lim) * f);
                if ($urandom_range(0, 1)) na = -na;
                if ($urandom_range(0, 1)) nb = -nb;
            end else begin
                na = random_numerator();
                nb = random_numerator();
                da = random_denominator();
                db = random_denominator();
            end
            send_fractions(cmd, na, da, nb, db);
            burst_left--;
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
